// ----- design/tsrq_pkg.sv -----
// ----------------------------------------------------------------------------
// TCP send and retransmit queue package
// Request and result types, operation and status codes, and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tsrq_pkg;

	localparam int COUNT_W = 7;

	typedef logic [2:0] kind_t;
	typedef logic [1:0] status_t;

	localparam kind_t KIND_ENQUEUE = 3'd0;
	localparam kind_t KIND_SEND    = 3'd1;
	localparam kind_t KIND_PEEK    = 3'd2;
	localparam kind_t KIND_ACK     = 3'd3;
	localparam kind_t KIND_FLUSH   = 3'd4;
	localparam kind_t KIND_COUNT   = 3'd5;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] seg_len;
		logic [15:0] buffer_handle;
		logic [31:0] seq;
		logic [4:0]  rank;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [15:0]          out_len;
		logic [15:0]          out_handle;
		logic [31:0]          out_seq;
		logic [COUNT_W-1:0]   entry_count;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic    take_item;
		logic    enq_write;
		logic    send_move;
		logic    rt_peek;
		logic    cap_peek;
		logic    ack_pop;
		logic    cap_sum;
		logic    flush;
		logic    set_status;
		status_t status;
		logic    load_out;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		kind_t kind;
		logic  pend_empty;
		logic  pend_full;
		logic  rt_full;
		logic  peek_miss;
		logic  ack_hit;
	} sts_t;

endpackage

// ----- design/tsrq_dp.sv -----
// ----------------------------------------------------------------------------
// TCP send and retransmit queue datapath
// Holds the request register, both descriptor memories with their pointers
// and fill counts, the result being built, and the result output register.
// ----------------------------------------------------------------------------
module tsrq_dp import tsrq_pkg::*; #(
	parameter int PENDING_DEPTH    = 32,
	parameter int RETRANSMIT_DEPTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req_data,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t rsp_data
);

	localparam int PPW = $clog2(PENDING_DEPTH);
	localparam int PFW = $clog2(PENDING_DEPTH + 1);
	localparam int RPW = $clog2(RETRANSMIT_DEPTH);
	localparam int RFW = $clog2(RETRANSMIT_DEPTH + 1);
	localparam int IW  = ((RPW > 5) ? RPW : 5) + 1;
	localparam int SW  = ((PFW > RFW) ? PFW : RFW) + 1;

	function automatic logic [PPW-1:0] p_inc(input logic [PPW-1:0] p);
		return (p == PPW'(PENDING_DEPTH - 1)) ? '0 : PPW'(p + PPW'(1));
	endfunction

	function automatic logic [RPW-1:0] r_inc(input logic [RPW-1:0] p);
		return (p == RPW'(RETRANSMIT_DEPTH - 1)) ? '0 : RPW'(p + RPW'(1));
	endfunction

	req_t             item_q;
	logic [PPW-1:0]   p_head_q, p_tail_q;
	logic [PFW-1:0]   p_fill_q;
	logic [RPW-1:0]   r_head_q, r_tail_q;
	logic [RFW-1:0]   r_fill_q;
	logic [31:0]      p_mem [PENDING_DEPTH];
	logic [63:0]      r_mem [RETRANSMIT_DEPTH];
	logic [31:0]      p_rd_q;
	logic [63:0]      r_rd_q;
	status_t          res_status_q;
	logic [15:0]      res_len_q, res_handle_q;
	logic [31:0]      res_seq_q;
	logic [COUNT_W-1:0] res_count_q;
	rsp_t             rsp_q;

	logic [IW-1:0]    peek_sum;
	logic [IW-1:0]    peek_idx;
	logic [RPW-1:0]   r_addr;
	logic [SW-1:0]    fill_sum;

	// The rank is below the fill, so one subtraction brings the index in range.
	always_comb begin
		peek_sum = IW'(r_head_q) + IW'(item_q.rank);
		peek_idx = (peek_sum >= IW'(RETRANSMIT_DEPTH)) ?
			IW'(peek_sum - IW'(RETRANSMIT_DEPTH)) : peek_sum;
		r_addr   = cmd.rt_peek ? RPW'(peek_idx) : r_head_q;
		fill_sum = SW'(p_fill_q) + SW'(r_fill_q);
	end

	assign sts.kind       = item_q.kind;
	assign sts.pend_empty = (p_fill_q == '0);
	assign sts.pend_full  = (p_fill_q == PFW'(PENDING_DEPTH));
	assign sts.rt_full    = (r_fill_q == RFW'(RETRANSMIT_DEPTH));
	assign sts.peek_miss  = (IW'(item_q.rank) >= IW'(r_fill_q));
	assign sts.ack_hit    = (r_fill_q != '0) && (r_rd_q[63:32] < item_q.seq);

	assign rsp_data = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_head_q <= '0;
			p_tail_q <= '0;
			p_fill_q <= '0;
			r_head_q <= '0;
			r_tail_q <= '0;
			r_fill_q <= '0;
		end else if (cmd.flush) begin
			p_head_q <= '0;
			p_tail_q <= '0;
			p_fill_q <= '0;
			r_head_q <= '0;
			r_tail_q <= '0;
			r_fill_q <= '0;
		end else if (cmd.enq_write) begin
			p_tail_q <= p_inc(p_tail_q);
			p_fill_q <= PFW'(p_fill_q + PFW'(1));
		end else if (cmd.send_move) begin
			p_head_q <= p_inc(p_head_q);
			p_fill_q <= PFW'(p_fill_q - PFW'(1));
			r_tail_q <= r_inc(r_tail_q);
			r_fill_q <= RFW'(r_fill_q + RFW'(1));
		end else if (cmd.ack_pop) begin
			r_head_q <= r_inc(r_head_q);
			r_fill_q <= RFW'(r_fill_q - RFW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq_write) begin
			p_mem[p_tail_q] <= {item_q.seg_len, item_q.buffer_handle};
		end
		p_rd_q <= p_mem[p_head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.send_move) begin
			r_mem[r_tail_q] <= {item_q.seq, p_rd_q};
		end
		r_rd_q <= r_mem[r_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			item_q       <= req_data;
			res_status_q <= ST_OK;
			res_len_q    <= '0;
			res_handle_q <= '0;
			res_seq_q    <= '0;
			res_count_q  <= '0;
		end else begin
			if (cmd.set_status) begin
				res_status_q <= cmd.status;
			end
			if (cmd.send_move) begin
				res_len_q    <= p_rd_q[31:16];
				res_handle_q <= p_rd_q[15:0];
				res_seq_q    <= item_q.seq;
			end
			if (cmd.cap_peek) begin
				res_len_q    <= r_rd_q[31:16];
				res_handle_q <= r_rd_q[15:0];
				res_seq_q    <= r_rd_q[63:32];
			end
			if (cmd.ack_pop) begin
				res_count_q <= COUNT_W'(res_count_q + COUNT_W'(1));
			end
			if (cmd.cap_sum) begin
				res_count_q <= COUNT_W'(fill_sum);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.status      <= res_status_q;
			rsp_q.out_len     <= res_len_q;
			rsp_q.out_handle  <= res_handle_q;
			rsp_q.out_seq     <= res_seq_q;
			rsp_q.entry_count <= res_count_q;
		end
	end

endmodule

// ----- design/tsrq_ctrl.sv -----
// ----------------------------------------------------------------------------
// TCP send and retransmit queue controller
// Sequences one request at a time through the datapath and owns the result
// valid flag.
// ----------------------------------------------------------------------------
module tsrq_ctrl import tsrq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SEND,
		S_PEEK,
		S_ACK_WAIT,
		S_ACK_CMP,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.take_item = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				unique case (sts.kind)
					KIND_ENQUEUE: begin
						if (sts.pend_full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else begin
							cmd.enq_write = 1'b1;
						end
					end
					KIND_SEND: begin
						if (sts.pend_empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else if (sts.rt_full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else begin
							state_d = S_SEND;
						end
					end
					KIND_PEEK: begin
						cmd.rt_peek = 1'b1;
						if (sts.peek_miss) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else begin
							state_d = S_PEEK;
						end
					end
					KIND_ACK: begin
						state_d = S_ACK_CMP;
					end
					KIND_FLUSH: begin
						cmd.cap_sum = 1'b1;
						cmd.flush   = 1'b1;
					end
					KIND_COUNT: begin
						cmd.cap_sum = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_SEND: begin
				cmd.send_move = 1'b1;
				state_d       = S_DONE;
			end
			S_PEEK: begin
				cmd.cap_peek = 1'b1;
				state_d      = S_DONE;
			end
			// The head tag is read in the cycle after the head pointer moves.
			S_ACK_WAIT: begin
				state_d = S_ACK_CMP;
			end
			S_ACK_CMP: begin
				if (sts.ack_hit) begin
					cmd.ack_pop = 1'b1;
					state_d     = S_ACK_WAIT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/tcp_send_and_retransmit_queue_unit.sv -----
// A result is loaded in S_DONE: enqueue, flush, count, unused kinds and a send or
// peek that fails go there from S_EXEC, a send or peek that succeeds passes S_SEND
// or S_PEEK first, and an ack release passes S_ACK_CMP and S_ACK_WAIT per freed entry.
// A new request is accepted at the earliest in the cycle after the previous result
// is loaded, so requests do not overlap; a stalled result output holds S_DONE.
// Reset clears pointers, fill counts and the controller; stores stay undefined.
// ----------------------------------------------------------------------------
// TCP send and retransmit queue unit
// Pending and retransmit descriptor FIFOs with send, peek, ack release, flush
// and count operations, built as a controller and a datapath.
// ----------------------------------------------------------------------------
module tcp_send_and_retransmit_queue_unit import tsrq_pkg::*; #(
	parameter int PENDING_DEPTH    = 32,
	parameter int RETRANSMIT_DEPTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	cmd_t cmd;
	sts_t sts;

	tsrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tsrq_dp #(
		.PENDING_DEPTH    (PENDING_DEPTH),
		.RETRANSMIT_DEPTH (RETRANSMIT_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_data (rsp_data)
	);

`ifndef SYNTHESIS
	// Only one request is in flight at a time.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while another is in flight");

	a_enq_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq_write |-> !sts.pend_full)
		else $error("enqueue written into a full pending queue");

	a_send_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.send_move |-> !sts.pend_empty && !sts.rt_full)
		else $error("send moved an entry without room or source");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> rsp_valid)
		else $error("loaded result not presented");
`endif

endmodule
